/* sv/rms_vector_normalizer_unit_assert.svh */
// ----------------------------------------------------------------------------
// rms vector normalizer assertion macros
// concurrent assertion wrappers, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef RMS_VECTOR_NORMALIZER_UNIT_ASSERT_SVH
`define RMS_VECTOR_NORMALIZER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked at every clock edge outside reset
`define RVN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition that must never hold outside reset
`define RVN_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define RVN_ASSERT(label, clk, rst, prop, msg)
`define RVN_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

/* sv/rvn_pkg.sv */
// ----------------------------------------------------------------------------
// rvn_pkg
// shared types and constants of the rms vector normalizer
// ----------------------------------------------------------------------------
package rvn_pkg;

   // vector and datapath sizes
   localparam int MaxDim     = 4096;
   localparam int CountW     = 13;
   localparam int SumW       = 45;
   localparam int InvW       = 32;
   localparam int NumW       = 63;
   localparam int DenW       = 46;
   localparam int RemW       = 47;
   localparam int DivCntW    = 6;
   localparam int SqrtSteps  = 32;
   localparam int SqrtCntW   = 5;
   localparam int ProdW      = 31;
   localparam int ScaledW    = 62;

   // request queue between front and back
   localparam int CmdDepth   = 4;
   localparam int CmdPtrW    = 2;
   localparam int CmdCntW    = 3;

   // result queue at the output
   localparam int OutDepth   = 2;
   localparam int OutPtrW    = 1;
   localparam int OutCntW    = 2;

   typedef enum logic {
      OP_ACCUM = 1'b0,
      OP_NORM  = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type         opcode;
      logic signed [15:0] value;
      logic signed [15:0] gain;
      logic               last;
   } cmd_type;

   typedef struct packed {
      logic signed [15:0] result;
      logic               saturated;
      logic               final_res;
   } rsp_type;

   // handshake between front queue and back engine
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ACC,
      ST_LOAD_MEAN,
      ST_DIV_MEAN,
      ST_LOAD_RECIP,
      ST_DIV_RECIP,
      ST_LOAD_SQRT,
      ST_SQRT,
      ST_MUL_GAIN,
      ST_MUL_SCALE,
      ST_OUT
   } state_type;

endpackage

/* sv/rvn_front.sv */
// ----------------------------------------------------------------------------
// rvn_front
// accepts requests and queues them for the back engine
// ----------------------------------------------------------------------------
module rvn_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  rvn_pkg::cmd_type      cmd_in,
   output rvn_pkg::cmd_chan_type chan,
   input  logic                  cmd_pop
);

   rvn_pkg::cmd_type                 mem_ff [rvn_pkg::CmdDepth];
   logic [rvn_pkg::CmdPtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [rvn_pkg::CmdPtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [rvn_pkg::CmdCntW-1:0]      count_ff, count_in;
   logic                             do_push;
   logic                             do_pop;

   // queue status
   assign full    = (count_ff == rvn_pkg::CmdCntW'(rvn_pkg::CmdDepth));
   assign do_push = push && !full;
   assign do_pop  = cmd_pop && (count_ff != '0);

   assign chan.valid = (count_ff != '0);
   assign chan.cmd   = mem_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // request storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

/* sv/rvn_back.sv */
// ----------------------------------------------------------------------------
// rvn_back
// accumulates squares, derives the inverse rms and scales pass 1 elements
// ----------------------------------------------------------------------------
`include "rms_vector_normalizer_unit_assert.svh"

module rvn_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rvn_pkg::cmd_chan_type chan,
   output logic                  cmd_pop,
   input  logic                  csr_write_en,
   input  logic [15:0]           csr_write_data,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rvn_pkg::rsp_type      rsp
);

   rvn_pkg::state_type                state_ff, state_in;
   rvn_pkg::cmd_type                  cmd_ff;
   logic [15:0]                       epsilon_ff;
   logic [rvn_pkg::SumW-1:0]          sum_ff;
   logic [rvn_pkg::CountW-1:0]        count_ff;
   logic [rvn_pkg::InvW-1:0]          inv_ff;
   logic                              scale_ready_ff;
   logic [rvn_pkg::NumW-1:0]          num_ff;
   logic [rvn_pkg::DenW-1:0]          den_ff;
   logic [rvn_pkg::RemW-1:0]          rem_ff;
   logic [rvn_pkg::DivCntW-1:0]       div_cnt_ff;
   logic [rvn_pkg::NumW-1:0]          sq_q_ff;
   logic [rvn_pkg::NumW-1:0]          sq_res_ff;
   logic [rvn_pkg::NumW-1:0]          sq_bit_ff;
   logic [rvn_pkg::SqrtCntW-1:0]      sq_cnt_ff;
   logic [rvn_pkg::ProdW-1:0]         prod_ff;
   logic [rvn_pkg::ScaledW-1:0]       scaled_ff;
   rvn_pkg::rsp_type                  out_mem_ff [rvn_pkg::OutDepth];
   logic [rvn_pkg::OutPtrW-1:0]       out_wr_ff;
   logic [rvn_pkg::OutPtrW-1:0]       out_rd_ff;
   logic [rvn_pkg::OutCntW-1:0]       out_count_ff, out_count_in;

   logic                              out_push;
   logic                              out_pop;
   logic                              div_last;
   logic                              sqrt_last;
   logic [16:0]                       x_ext, w_ext;
   logic [16:0]                       x_mag, w_mag;
   logic [33:0]                       x_sq;
   logic [33:0]                       xw;
   logic                              under_max;
   logic [rvn_pkg::RemW-1:0]          rem_shift;
   logic                              rem_ge;
   logic [rvn_pkg::DenW-1:0]          mean_sq;
   logic [rvn_pkg::NumW-1:0]          sq_trial;
   logic                              sq_ge;
   logic [rvn_pkg::NumW-1:0]          sq_q_next;
   logic [rvn_pkg::NumW-1:0]          sq_res_next;
   logic [rvn_pkg::NumW:0]            rounded;
   logic [31:0]                       mag_r;
   logic                              neg;
   rvn_pkg::rsp_type                  rsp_new;

   // element magnitudes
   assign x_ext     = {cmd_ff.value[15], cmd_ff.value};
   assign w_ext     = {cmd_ff.gain[15], cmd_ff.gain};
   assign x_mag     = cmd_ff.value[15] ? 17'(~x_ext + 17'd1) : x_ext;
   assign w_mag     = cmd_ff.gain[15]  ? 17'(~w_ext + 17'd1) : w_ext;
   assign x_sq      = x_mag * x_mag;
   assign xw        = x_mag * w_mag;
   assign under_max = (count_ff < rvn_pkg::CountW'(rvn_pkg::MaxDim));

   // shared restoring divider step
   assign rem_shift = {rem_ff[rvn_pkg::RemW-2:0], num_ff[rvn_pkg::NumW-1]};
   assign rem_ge    = (rem_shift >= {1'b0, den_ff});
   assign div_last  = (div_cnt_ff == rvn_pkg::DivCntW'(rvn_pkg::NumW - 1));

   // mean square plus epsilon, empty vector gives epsilon alone
   assign mean_sq = ((count_ff == '0) ? '0 : rvn_pkg::DenW'(num_ff[rvn_pkg::SumW-1:0]))
                    + rvn_pkg::DenW'(epsilon_ff);

   // integer square root step
   assign sq_trial    = sq_res_ff + sq_bit_ff;
   assign sq_ge       = (sq_q_ff >= sq_trial);
   assign sq_q_next   = sq_ge ? sq_q_ff - sq_trial : sq_q_ff;
   assign sq_res_next = sq_ge ? (sq_res_ff >> 1) + sq_bit_ff : (sq_res_ff >> 1);
   assign sqrt_last   = (sq_cnt_ff == rvn_pkg::SqrtCntW'(rvn_pkg::SqrtSteps - 1));

   // round to nearest at bit 31 and saturate
   assign rounded = {1'b0, rvn_pkg::NumW'(scaled_ff)} + (64'd1 << 30);
   assign mag_r   = rounded[62:31];
   assign neg     = cmd_ff.value[15] ^ cmd_ff.gain[15];

   always_comb begin
      rsp_new.result    = '0;
      rsp_new.saturated = 1'b0;
      rsp_new.final_res = cmd_ff.last;
      if (scale_ready_ff) begin
         if (neg) begin
            if (mag_r > 32'd32768) begin
               rsp_new.result    = 16'sh8000;
               rsp_new.saturated = 1'b1;
            end else begin
               rsp_new.result = 16'(~mag_r + 32'd1);
            end
         end else begin
            if (mag_r > 32'd32767) begin
               rsp_new.result    = 16'sh7fff;
               rsp_new.saturated = 1'b1;
            end else begin
               rsp_new.result = 16'(mag_r);
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rvn_pkg::ST_IDLE: begin
            if (chan.valid) begin
               state_in = (chan.cmd.opcode == rvn_pkg::OP_ACCUM) ?
                          rvn_pkg::ST_ACC : rvn_pkg::ST_MUL_GAIN;
            end
         end
         rvn_pkg::ST_ACC: begin
            state_in = cmd_ff.last ? rvn_pkg::ST_LOAD_MEAN : rvn_pkg::ST_IDLE;
         end
         rvn_pkg::ST_LOAD_MEAN:  state_in = rvn_pkg::ST_DIV_MEAN;
         rvn_pkg::ST_DIV_MEAN: begin
            if (div_last) state_in = rvn_pkg::ST_LOAD_RECIP;
         end
         rvn_pkg::ST_LOAD_RECIP: begin
            state_in = (mean_sq == '0) ? rvn_pkg::ST_IDLE : rvn_pkg::ST_DIV_RECIP;
         end
         rvn_pkg::ST_DIV_RECIP: begin
            if (div_last) state_in = rvn_pkg::ST_LOAD_SQRT;
         end
         rvn_pkg::ST_LOAD_SQRT:  state_in = rvn_pkg::ST_SQRT;
         rvn_pkg::ST_SQRT: begin
            if (sqrt_last) state_in = rvn_pkg::ST_IDLE;
         end
         rvn_pkg::ST_MUL_GAIN:   state_in = rvn_pkg::ST_MUL_SCALE;
         rvn_pkg::ST_MUL_SCALE:  state_in = rvn_pkg::ST_OUT;
         rvn_pkg::ST_OUT: begin
            if (out_push) state_in = rvn_pkg::ST_IDLE;
         end
         default: state_in = rvn_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      cmd_pop  = 1'b0;
      out_push = 1'b0;
      case (state_ff)
         rvn_pkg::ST_IDLE: cmd_pop  = chan.valid;
         rvn_pkg::ST_OUT:  out_push = (out_count_ff != rvn_pkg::OutCntW'(rvn_pkg::OutDepth));
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rvn_pkg::ST_IDLE;
         epsilon_ff     <= 16'd1;
         sum_ff         <= '0;
         count_ff       <= '0;
         inv_ff         <= '0;
         scale_ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            epsilon_ff <= csr_write_data;
         end
         case (state_ff)
            rvn_pkg::ST_ACC: begin
               if (under_max) begin
                  sum_ff   <= sum_ff + rvn_pkg::SumW'(x_sq);
                  count_ff <= count_ff + 1'b1;
               end
            end
            rvn_pkg::ST_LOAD_RECIP: begin
               if (mean_sq == '0) begin
                  inv_ff         <= '1;
                  scale_ready_ff <= 1'b1;
                  sum_ff         <= '0;
                  count_ff       <= '0;
               end
            end
            rvn_pkg::ST_SQRT: begin
               if (sqrt_last) begin
                  inv_ff         <= sq_res_next[rvn_pkg::InvW-1:0];
                  scale_ready_ff <= 1'b1;
                  sum_ff         <= '0;
                  count_ff       <= '0;
               end
            end
            rvn_pkg::ST_OUT: begin
               if (out_push && cmd_ff.last) begin
                  scale_ready_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= chan.cmd;
      end
      case (state_ff)
         rvn_pkg::ST_LOAD_MEAN: begin
            num_ff     <= rvn_pkg::NumW'(sum_ff);
            den_ff     <= rvn_pkg::DenW'(count_ff);
            rem_ff     <= '0;
            div_cnt_ff <= '0;
         end
         rvn_pkg::ST_LOAD_RECIP: begin
            num_ff     <= rvn_pkg::NumW'(1) << 62;
            den_ff     <= mean_sq;
            rem_ff     <= '0;
            div_cnt_ff <= '0;
         end
         rvn_pkg::ST_DIV_MEAN, rvn_pkg::ST_DIV_RECIP: begin
            num_ff     <= {num_ff[rvn_pkg::NumW-2:0], rem_ge};
            rem_ff     <= rem_ge ? rem_shift - {1'b0, den_ff} : rem_shift;
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         rvn_pkg::ST_LOAD_SQRT: begin
            sq_q_ff   <= num_ff;
            sq_res_ff <= '0;
            sq_bit_ff <= rvn_pkg::NumW'(1) << 62;
            sq_cnt_ff <= '0;
         end
         rvn_pkg::ST_SQRT: begin
            sq_q_ff   <= sq_q_next;
            sq_res_ff <= sq_res_next;
            sq_bit_ff <= sq_bit_ff >> 2;
            sq_cnt_ff <= sq_cnt_ff + 1'b1;
         end
         rvn_pkg::ST_MUL_GAIN:  prod_ff   <= xw[rvn_pkg::ProdW-1:0];
         rvn_pkg::ST_MUL_SCALE: begin
            scaled_ff <= rvn_pkg::ScaledW'(prod_ff) * rvn_pkg::ScaledW'(inv_ff);
         end
         default: ;
      endcase
   end

   // result queue
   assign out_pop   = rsp_pop && (out_count_ff != '0);
   assign rsp_empty = (out_count_ff == '0);
   assign rsp       = out_mem_ff[out_rd_ff];

   always_comb begin
      out_count_in = out_count_ff;
      if (out_push && !out_pop) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (!out_push && out_pop) begin
         out_count_in = out_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         if (out_push) out_wr_ff <= out_wr_ff + 1'b1;
         if (out_pop)  out_rd_ff <= out_rd_ff + 1'b1;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= rsp_new;
      end
   end

   // checks
   `RVN_ASSERT_NEVER(a_out_bound, clock, reset,
      out_count_ff > rvn_pkg::OutCntW'(rvn_pkg::OutDepth), "result queue overfilled")
   `RVN_ASSERT(a_sqrt_done, clock, reset,
      (state_ff == rvn_pkg::ST_SQRT && sqrt_last) |=> scale_ready_ff && count_ff == '0,
      "scale not fixed after square root")
   `RVN_ASSERT(a_zero_mean, clock, reset,
      (state_ff == rvn_pkg::ST_LOAD_RECIP && mean_sq == '0) |=> inv_ff == '1,
      "zero mean square did not saturate scale")
   `RVN_ASSERT(a_pass_end, clock, reset,
      (out_push && cmd_ff.last) |=> !scale_ready_ff,
      "scale still ready after last normalize request")

endmodule

/* sv/rms_vector_normalizer_unit.sv */
// ----------------------------------------------------------------------------
// rms_vector_normalizer_unit
// rms layer normalization of one streamed vector with per-element gain
// ----------------------------------------------------------------------------
// requests enter on req_* (push/full); opcode 0 adds the element square to
// the running sum, opcode 1 returns one scaled element on rsp_* (empty/pop).
// the request marked last in pass 0 fixes the scale: a 63-step mean divide,
// a 63-step reciprocal divide and a 32-step square root in the back engine,
// during which later requests wait in the queue. a pass 1 request passes
// through a gain multiply and a scale multiply, then waits for room in the
// result queue. the front queue holds 4 requests and the result queue 2.
// csr_write_en/csr_write_data load epsilon (reset value 1); the user must
// write it only while idle, the block itself does not enforce this.
// reset is synchronous: it empties both queues, clears the sum, count and
// scale, and sets epsilon to 1. when the receiver stops popping, the result
// queue fills, the back engine holds its finished result, and full rises
// once the front queue is full; no request or result is lost.
// ----------------------------------------------------------------------------
module rms_vector_normalizer_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_opcode,
   input  logic signed [15:0] req_value,
   input  logic signed [15:0] req_gain,
   input  logic               req_last,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_result,
   output logic               rsp_saturated,
   output logic               rsp_final_res,
   input  logic               csr_write_en,
   input  logic [15:0]        csr_write_data
);

   rvn_pkg::cmd_type      cmd_in;
   rvn_pkg::cmd_chan_type chan;
   logic                  cmd_pop;
   rvn_pkg::rsp_type      rsp;

   // request packing
   assign cmd_in.opcode = rvn_pkg::opcode_type'(req_opcode);
   assign cmd_in.value  = req_value;
   assign cmd_in.gain   = req_gain;
   assign cmd_in.last   = req_last;

   rvn_front u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .full    (req_full),
      .cmd_in  (cmd_in),
      .chan    (chan),
      .cmd_pop (cmd_pop)
   );

   rvn_back u_back (
      .clock          (clock),
      .reset          (reset),
      .chan           (chan),
      .cmd_pop        (cmd_pop),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp            (rsp)
   );

   // result unpacking
   assign rsp_result    = rsp.result;
   assign rsp_saturated = rsp.saturated;
   assign rsp_final_res = rsp.final_res;

endmodule
